// ===== rtl/cpfi_pkg.sv =====
// ----------------------------------------------------------------------------
// cpfi_pkg
// Shared types, constants, saturation helpers and the microcode ROM of the
// charged particle field integrator.
// ----------------------------------------------------------------------------
package cpfi_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int TW = 47;
    localparam int CW = 32;
    localparam int PCW = 7;

    localparam logic signed [DW-1:0] VMAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] QONE  = DW'(1) <<< FB;
    localparam logic signed [DW-1:0] QHALF = DW'(1) <<< (FB - 1);

    typedef enum logic [1:0] {
        OPC_LOAD  = 2'd0,
        OPC_STEP  = 2'd1,
        OPC_FLUSH = 2'd2,
        OPC_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        SCH_EULER  = 2'd0,
        SCH_CROMER = 2'd1,
        SCH_VERLET = 2'd2,
        SCH_RK2    = 2'd3
    } scheme_t;

    typedef enum logic [2:0] {
        REG_SCHEME   = 3'd0,
        REG_DT       = 3'd1,
        REG_MASS     = 3'd2,
        REG_CHARGE   = 3'd3,
        REG_FBASE    = 3'd4,
        REG_FGRAD    = 3'd5,
        REG_EFIELD   = 3'd6,
        REG_INTERVAL = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_END,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } uop_code_t;

    typedef enum logic [4:0] {
        S_PX, S_PY, S_VX, S_VY,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8,
        S_DT, S_HD, S_QM, S_MASS, S_CHG, S_FB, S_FG, S_EF, S_HALF, S_ONE
    } src_t;

    typedef struct packed {
        uop_code_t op;
        src_t      dst;
        src_t      a;
        src_t      b;
    } uop_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DELIVER
    } ctrl_state_t;

    typedef struct packed {
        logic issue;
        uop_t uop;
        logic load;
        logic tadv;
        logic capture;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_stat_t;

    localparam logic [PCW-1:0] PC_EULER  = PCW'(0);
    localparam logic [PCW-1:0] PC_CROMER = PCW'(19);
    localparam logic [PCW-1:0] PC_VERLET = PCW'(38);
    localparam logic [PCW-1:0] PC_RK2    = PCW'(66);
    localparam logic [PCW-1:0] PC_EMIT   = PCW'(103);
    localparam int UC_DEPTH = 116;

    localparam uop_t UCODE [UC_DEPTH] = '{
        // explicit Euler, old velocities move the position
        '{OP_DIV, S_QM, S_CHG, S_MASS}, '{OP_MUL, S_HD, S_DT, S_HALF},
        '{OP_MUL, S_T0, S_FG, S_PX},    '{OP_ADD, S_T0, S_ONE, S_T0},
        '{OP_MUL, S_T0, S_FB, S_T0},    '{OP_MUL, S_T1, S_QM, S_T0},
        '{OP_MUL, S_T2, S_T1, S_VY},    '{OP_MUL, S_T3, S_T0, S_VX},
        '{OP_SUB, S_T3, S_EF, S_T3},    '{OP_MUL, S_T3, S_QM, S_T3},
        '{OP_MUL, S_T4, S_VX, S_DT},    '{OP_ADD, S_PX, S_PX, S_T4},
        '{OP_MUL, S_T4, S_VY, S_DT},    '{OP_ADD, S_PY, S_PY, S_T4},
        '{OP_MUL, S_T4, S_T2, S_DT},    '{OP_ADD, S_VX, S_VX, S_T4},
        '{OP_MUL, S_T4, S_T3, S_DT},    '{OP_ADD, S_VY, S_VY, S_T4},
        '{OP_END, S_PX, S_PX, S_PX},
        // Euler-Cromer
        '{OP_DIV, S_QM, S_CHG, S_MASS}, '{OP_MUL, S_HD, S_DT, S_HALF},
        '{OP_MUL, S_T0, S_FG, S_PX},    '{OP_ADD, S_T0, S_ONE, S_T0},
        '{OP_MUL, S_T0, S_FB, S_T0},    '{OP_MUL, S_T1, S_QM, S_T0},
        '{OP_MUL, S_T1, S_T1, S_VY},    '{OP_MUL, S_T1, S_T1, S_DT},
        '{OP_ADD, S_VX, S_VX, S_T1},    '{OP_MUL, S_T1, S_T0, S_VX},
        '{OP_SUB, S_T1, S_EF, S_T1},    '{OP_MUL, S_T1, S_QM, S_T1},
        '{OP_MUL, S_T1, S_T1, S_DT},    '{OP_ADD, S_VY, S_VY, S_T1},
        '{OP_MUL, S_T1, S_VX, S_DT},    '{OP_ADD, S_PX, S_PX, S_T1},
        '{OP_MUL, S_T1, S_VY, S_DT},    '{OP_ADD, S_PY, S_PY, S_T1},
        '{OP_END, S_PX, S_PX, S_PX},
        // symmetric Verlet
        '{OP_DIV, S_QM, S_CHG, S_MASS}, '{OP_MUL, S_HD, S_DT, S_HALF},
        '{OP_MUL, S_T1, S_VX, S_HD},    '{OP_ADD, S_PX, S_PX, S_T1},
        '{OP_MUL, S_T1, S_VY, S_HD},    '{OP_ADD, S_PY, S_PY, S_T1},
        '{OP_MUL, S_T0, S_FG, S_PX},    '{OP_ADD, S_T0, S_ONE, S_T0},
        '{OP_MUL, S_T0, S_FB, S_T0},    '{OP_MUL, S_T1, S_QM, S_T0},
        '{OP_MUL, S_T1, S_T1, S_VY},    '{OP_MUL, S_T1, S_T1, S_HD},
        '{OP_ADD, S_VX, S_VX, S_T1},    '{OP_MUL, S_T1, S_T0, S_VX},
        '{OP_SUB, S_T1, S_EF, S_T1},    '{OP_MUL, S_T1, S_QM, S_T1},
        '{OP_MUL, S_T1, S_T1, S_HD},    '{OP_ADD, S_VY, S_VY, S_T1},
        '{OP_ADD, S_VY, S_VY, S_T1},    '{OP_MUL, S_T1, S_QM, S_T0},
        '{OP_MUL, S_T1, S_T1, S_VY},    '{OP_MUL, S_T1, S_T1, S_HD},
        '{OP_ADD, S_VX, S_VX, S_T1},    '{OP_MUL, S_T1, S_VY, S_HD},
        '{OP_ADD, S_PY, S_PY, S_T1},    '{OP_MUL, S_T1, S_VX, S_HD},
        '{OP_ADD, S_PX, S_PX, S_T1},    '{OP_END, S_PX, S_PX, S_PX},
        // midpoint RK2
        '{OP_DIV, S_QM, S_CHG, S_MASS}, '{OP_MUL, S_HD, S_DT, S_HALF},
        '{OP_MUL, S_T0, S_FG, S_PX},    '{OP_ADD, S_T0, S_ONE, S_T0},
        '{OP_MUL, S_T0, S_FB, S_T0},    '{OP_MUL, S_T1, S_QM, S_T0},
        '{OP_MUL, S_T1, S_T1, S_VY},    '{OP_MUL, S_T2, S_DT, S_T1},
        '{OP_MUL, S_T1, S_T0, S_VX},    '{OP_SUB, S_T1, S_EF, S_T1},
        '{OP_MUL, S_T1, S_QM, S_T1},    '{OP_MUL, S_T3, S_DT, S_T1},
        '{OP_MUL, S_T4, S_DT, S_VX},    '{OP_MUL, S_T5, S_DT, S_VY},
        '{OP_MUL, S_T1, S_HALF, S_T2},  '{OP_ADD, S_T6, S_VX, S_T1},
        '{OP_MUL, S_T1, S_HALF, S_T3},  '{OP_ADD, S_T7, S_VY, S_T1},
        '{OP_MUL, S_T1, S_HALF, S_T4},  '{OP_ADD, S_T8, S_PX, S_T1},
        '{OP_MUL, S_T0, S_FG, S_T8},    '{OP_ADD, S_T0, S_ONE, S_T0},
        '{OP_MUL, S_T0, S_FB, S_T0},    '{OP_MUL, S_T1, S_QM, S_T0},
        '{OP_MUL, S_T1, S_T1, S_T7},    '{OP_MUL, S_T2, S_DT, S_T1},
        '{OP_MUL, S_T1, S_T0, S_T6},    '{OP_SUB, S_T1, S_EF, S_T1},
        '{OP_MUL, S_T1, S_QM, S_T1},    '{OP_MUL, S_T3, S_DT, S_T1},
        '{OP_MUL, S_T4, S_DT, S_T6},    '{OP_MUL, S_T5, S_DT, S_T7},
        '{OP_ADD, S_VX, S_VX, S_T2},    '{OP_ADD, S_VY, S_VY, S_T3},
        '{OP_ADD, S_PX, S_PX, S_T4},    '{OP_ADD, S_PY, S_PY, S_T5},
        '{OP_END, S_PX, S_PX, S_PX},
        // diagnostics: T1 kinetic, T3 energy, T4 moment
        '{OP_MUL, S_T1, S_VX, S_VX},    '{OP_MUL, S_T2, S_VY, S_VY},
        '{OP_ADD, S_T1, S_T1, S_T2},    '{OP_MUL, S_T1, S_MASS, S_T1},
        '{OP_MUL, S_T1, S_HALF, S_T1},  '{OP_MUL, S_T2, S_CHG, S_EF},
        '{OP_MUL, S_T2, S_T2, S_PY},    '{OP_SUB, S_T3, S_T1, S_T2},
        '{OP_MUL, S_T0, S_FG, S_PX},    '{OP_ADD, S_T0, S_ONE, S_T0},
        '{OP_MUL, S_T0, S_FB, S_T0},    '{OP_DIV, S_T4, S_T1, S_T0},
        '{OP_END, S_PX, S_PX, S_PX}
    };

    function automatic logic signed [DW-1:0] sat_sum(input logic signed [DW:0] v);
        logic signed [DW-1:0] r;
        if (v[DW] != v[DW-1]) begin
            r = v[DW] ? VMIN : VMAX;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    // floor(p / 2^FB), clipped to the data range
    function automatic logic signed [DW-1:0] sat_prod(input logic signed [2*DW-1:0] p);
        logic signed [2*DW-1:0] s;
        logic signed [DW-1:0]   r;
        s = p >>> FB;
        if ((s[2*DW-1:DW-1] == '0) || (s[2*DW-1:DW-1] == '1)) begin
            r = s[DW-1:0];
        end else begin
            r = s[2*DW-1] ? VMIN : VMAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/charged_particle_field_integrator_top.sv =====
// Micro-ops run one at a time; a DIV yields one quotient bit per cycle over 48
// bits and returns its saturated result without iterating for a zero divisor.
// A step may also emit a sample; a load or an emitting flush only emits one,
// and delivery waits while the previous result beat is still pending. One item
// at a time. Synchronous active-low reset clears state, counters, configuration
// and particle registers; scratch and result registers are not reset.
// ----------------------------------------------------------------------------
// charged_particle_field_integrator_top
// Charged particle pusher in a graded magnetic field: configuration
// registers, controller and datapath.
// ----------------------------------------------------------------------------
module charged_particle_field_integrator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [cpfi_pkg::CW-1:0]        cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_opcode,
    input  logic signed [cpfi_pkg::DW-1:0] s_init_pos_x,
    input  logic signed [cpfi_pkg::DW-1:0] s_init_pos_y,
    input  logic signed [cpfi_pkg::DW-1:0] s_init_vel_x,
    input  logic signed [cpfi_pkg::DW-1:0] s_init_vel_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cpfi_pkg::TW-1:0]        m_time_out,
    output logic signed [cpfi_pkg::DW-1:0] m_out_pos_x,
    output logic signed [cpfi_pkg::DW-1:0] m_out_pos_y,
    output logic signed [cpfi_pkg::DW-1:0] m_out_vel_x,
    output logic signed [cpfi_pkg::DW-1:0] m_out_vel_y,
    output logic signed [cpfi_pkg::DW-1:0] m_total_energy,
    output logic signed [cpfi_pkg::DW-1:0] m_magnetic_moment
);
    import cpfi_pkg::*;

    logic [1:0]           scheme_reg;
    logic [30:0]          dt_reg;
    logic [30:0]          mass_reg;
    logic signed [DW-1:0] charge_reg, fbase_reg, fgrad_reg, efield_reg;
    logic [15:0]          interval_reg;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scheme_reg   <= SCH_EULER;
            dt_reg       <= 31'd65;
            mass_reg     <= 31'd65536;
            charge_reg   <= QONE;
            fbase_reg    <= QONE;
            fgrad_reg    <= '0;
            efield_reg   <= '0;
            interval_reg <= 16'd1;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCHEME:   scheme_reg   <= cfg_wdata[1:0];
                REG_DT:       dt_reg       <= cfg_wdata[30:0];
                REG_MASS:     mass_reg     <= cfg_wdata[30:0];
                REG_CHARGE:   charge_reg   <= cfg_wdata;
                REG_FBASE:    fbase_reg    <= cfg_wdata;
                REG_FGRAD:    fgrad_reg    <= cfg_wdata;
                REG_EFIELD:   efield_reg   <= cfg_wdata;
                REG_INTERVAL: interval_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    cpfi_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .scheme_select  (scheme_reg),
        .sample_interval(interval_reg),
        .cmd            (cmd),
        .stat           (stat)
    );

    cpfi_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .time_step      (dt_reg),
        .particle_mass  (mass_reg),
        .particle_charge(charge_reg),
        .field_base     (fbase_reg),
        .field_gradient (fgrad_reg),
        .electric_field (efield_reg),
        .init_pos_x     (s_init_pos_x),
        .init_pos_y     (s_init_pos_y),
        .init_vel_x     (s_init_vel_x),
        .init_vel_y     (s_init_vel_y),
        .time_out       (m_time_out),
        .out_pos_x      (m_out_pos_x),
        .out_pos_y      (m_out_pos_y),
        .out_vel_x      (m_out_vel_x),
        .out_vel_y      (m_out_vel_y),
        .total_energy   (m_total_energy),
        .magnetic_moment(m_magnetic_moment)
    );

    // a result beat is never overwritten while it still waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> (!m_valid || m_ready))
        else $error("result overwritten while pending");

    // no micro-op is issued while the input side is open
    a_issue_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !s_ready)
        else $error("micro-op issued while idle");

    // load and time advance only happen on an accepted beat
    a_load_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load || cmd.tadv) |-> (s_valid && s_ready))
        else $error("state update without accepted beat");

endmodule

// ===== rtl/cpfi_div.sv =====
// ----------------------------------------------------------------------------
// cpfi_div
// Restoring fixed point divider: a*2^FB/b, truncated toward zero, saturated.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpfi_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [cpfi_pkg::DW-1:0] num,
    input  logic signed [cpfi_pkg::DW-1:0] den,
    output logic                          done,
    output logic signed [cpfi_pkg::DW-1:0] quot
);
    import cpfi_pkg::*;

    localparam int NW = DW + FB;
    localparam int CNTW = $clog2(NW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [NW-1:0]     dvd_reg, dvd_next;
    logic [NW-1:0]     q_reg, q_next;
    logic [DW-1:0]     ub_reg, ub_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    logic signed [DW-1:0] zres_reg, zres_next;

    logic [DW:0]   trial;
    logic [DW-1:0] ua;
    logic [NW:0]   lim;
    logic [NW:0]   mag;

    always_comb begin
        ua = num[DW-1] ? DW'(-num) : DW'(num);
        trial = {rem_reg, dvd_reg[NW-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        ub_next   = ub_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        zres_next = zres_reg;
        if (start) begin
            neg_next  = num[DW-1] ^ den[DW-1];
            ub_next   = den[DW-1] ? DW'(-den) : DW'(den);
            dvd_next  = {ua, {FB{1'b0}}};
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = CNTW'(NW);
            zero_next = (den == '0);
            zres_next = num[DW-1] ? VMIN : VMAX;
            if (den == '0) begin
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (trial >= {1'b0, ub_reg}) begin
                rem_next = DW'(trial - {1'b0, ub_reg});
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            dvd_next = {dvd_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        q_reg    <= q_next;
        ub_reg   <= ub_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        zres_reg <= zres_next;
    end

    always_comb begin
        lim = neg_reg ? (NW+1)'({1'b1, {(DW-1){1'b0}}}) : (NW+1)'(VMAX);
        mag = ({1'b0, q_reg} > lim) ? lim : {1'b0, q_reg};
        if (zero_reg) begin
            quot = zres_reg;
        end else if (neg_reg) begin
            quot = DW'(-mag);
        end else begin
            quot = DW'(mag);
        end
    end

    assign done = done_reg;

endmodule

// ===== rtl/cpfi_dp.sv =====
// ----------------------------------------------------------------------------
// cpfi_dp
// Datapath: particle state, scratch registers, shared multiplier and
// divider, time accumulator and the result register.
// ----------------------------------------------------------------------------
module cpfi_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cpfi_pkg::dp_cmd_t              cmd,
    output cpfi_pkg::dp_stat_t             stat,
    input  logic [30:0]                    time_step,
    input  logic [30:0]                    particle_mass,
    input  logic signed [cpfi_pkg::DW-1:0] particle_charge,
    input  logic signed [cpfi_pkg::DW-1:0] field_base,
    input  logic signed [cpfi_pkg::DW-1:0] field_gradient,
    input  logic signed [cpfi_pkg::DW-1:0] electric_field,
    input  logic signed [cpfi_pkg::DW-1:0] init_pos_x,
    input  logic signed [cpfi_pkg::DW-1:0] init_pos_y,
    input  logic signed [cpfi_pkg::DW-1:0] init_vel_x,
    input  logic signed [cpfi_pkg::DW-1:0] init_vel_y,
    output logic [cpfi_pkg::TW-1:0]        time_out,
    output logic signed [cpfi_pkg::DW-1:0] out_pos_x,
    output logic signed [cpfi_pkg::DW-1:0] out_pos_y,
    output logic signed [cpfi_pkg::DW-1:0] out_vel_x,
    output logic signed [cpfi_pkg::DW-1:0] out_vel_y,
    output logic signed [cpfi_pkg::DW-1:0] total_energy,
    output logic signed [cpfi_pkg::DW-1:0] magnetic_moment
);
    import cpfi_pkg::*;

    logic signed [DW-1:0] px_reg, py_reg, vx_reg, vy_reg;
    logic signed [DW-1:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [DW-1:0] t5_reg, t6_reg, t7_reg, t8_reg;
    logic signed [DW-1:0] hd_reg, qm_reg;
    logic [TW-1:0]        time_reg;

    logic signed [2*DW-1:0] prod_reg;
    logic signed [DW-1:0]   add_res_reg;
    logic                   mul_pend_reg, add_pend_reg;
    src_t                   dst_reg;

    logic signed [DW-1:0] a_val, b_val, wb_val, div_q;
    logic                 wb_en, div_done;
    logic [TW:0]          time_sum;

    function automatic logic signed [DW-1:0] pick(input src_t s,
            input logic signed [DW-1:0] px, input logic signed [DW-1:0] py,
            input logic signed [DW-1:0] vx, input logic signed [DW-1:0] vy,
            input logic signed [DW-1:0] t0, input logic signed [DW-1:0] t1,
            input logic signed [DW-1:0] t2, input logic signed [DW-1:0] t3,
            input logic signed [DW-1:0] t4, input logic signed [DW-1:0] t5,
            input logic signed [DW-1:0] t6, input logic signed [DW-1:0] t7,
            input logic signed [DW-1:0] t8, input logic signed [DW-1:0] hd,
            input logic signed [DW-1:0] qm, input logic signed [DW-1:0] dt,
            input logic signed [DW-1:0] ms, input logic signed [DW-1:0] ch,
            input logic signed [DW-1:0] fb, input logic signed [DW-1:0] fg,
            input logic signed [DW-1:0] ef);
        logic signed [DW-1:0] r;
        unique case (s)
            S_PX:   r = px;
            S_PY:   r = py;
            S_VX:   r = vx;
            S_VY:   r = vy;
            S_T0:   r = t0;
            S_T1:   r = t1;
            S_T2:   r = t2;
            S_T3:   r = t3;
            S_T4:   r = t4;
            S_T5:   r = t5;
            S_T6:   r = t6;
            S_T7:   r = t7;
            S_T8:   r = t8;
            S_DT:   r = dt;
            S_HD:   r = hd;
            S_QM:   r = qm;
            S_MASS: r = ms;
            S_CHG:  r = ch;
            S_FB:   r = fb;
            S_FG:   r = fg;
            S_EF:   r = ef;
            S_HALF: r = QHALF;
            S_ONE:  r = QONE;
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb begin
        a_val = pick(cmd.uop.a, px_reg, py_reg, vx_reg, vy_reg, t0_reg, t1_reg,
                     t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg, t8_reg,
                     hd_reg, qm_reg, DW'(time_step), DW'(particle_mass),
                     particle_charge, field_base, field_gradient, electric_field);
        b_val = pick(cmd.uop.b, px_reg, py_reg, vx_reg, vy_reg, t0_reg, t1_reg,
                     t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg, t8_reg,
                     hd_reg, qm_reg, DW'(time_step), DW'(particle_mass),
                     particle_charge, field_base, field_gradient, electric_field);
    end

    cpfi_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.issue && (cmd.uop.op == OP_DIV)),
        .num    (a_val),
        .den    (b_val),
        .done   (div_done),
        .quot   (div_q)
    );

    always_comb begin
        wb_en = mul_pend_reg | add_pend_reg | div_done;
        priority if (mul_pend_reg) begin
            wb_val = sat_prod(prod_reg);
        end else if (add_pend_reg) begin
            wb_val = add_res_reg;
        end else begin
            wb_val = div_q;
        end
        time_sum = {1'b0, time_reg} + (TW+1)'(time_step);
    end

    assign stat.done = wb_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_pend_reg <= 1'b0;
            add_pend_reg <= 1'b0;
            px_reg   <= '0;
            py_reg   <= '0;
            vx_reg   <= '0;
            vy_reg   <= '0;
            time_reg <= '0;
        end else begin
            mul_pend_reg <= cmd.issue && (cmd.uop.op == OP_MUL);
            add_pend_reg <= cmd.issue && ((cmd.uop.op == OP_ADD) || (cmd.uop.op == OP_SUB));
            if (cmd.load) begin
                px_reg   <= init_pos_x;
                py_reg   <= init_pos_y;
                vx_reg   <= init_vel_x;
                vy_reg   <= init_vel_y;
                time_reg <= '0;
            end else begin
                if (cmd.tadv) begin
                    time_reg <= time_sum[TW] ? {TW{1'b1}} : time_sum[TW-1:0];
                end
                if (wb_en) begin
                    unique case (dst_reg)
                        S_PX:    px_reg <= wb_val;
                        S_PY:    py_reg <= wb_val;
                        S_VX:    vx_reg <= wb_val;
                        S_VY:    vy_reg <= wb_val;
                        default: ;
                    endcase
                end
            end
        end
        if (cmd.issue) begin
            dst_reg     <= cmd.uop.dst;
            prod_reg    <= a_val * b_val;
            add_res_reg <= (cmd.uop.op == OP_SUB)
                         ? sat_sum({a_val[DW-1], a_val} - {b_val[DW-1], b_val})
                         : sat_sum({a_val[DW-1], a_val} + {b_val[DW-1], b_val});
        end
        if (wb_en) begin
            unique case (dst_reg)
                S_T0:    t0_reg <= wb_val;
                S_T1:    t1_reg <= wb_val;
                S_T2:    t2_reg <= wb_val;
                S_T3:    t3_reg <= wb_val;
                S_T4:    t4_reg <= wb_val;
                S_T5:    t5_reg <= wb_val;
                S_T6:    t6_reg <= wb_val;
                S_T7:    t7_reg <= wb_val;
                S_T8:    t8_reg <= wb_val;
                S_HD:    hd_reg <= wb_val;
                S_QM:    qm_reg <= wb_val;
                default: ;
            endcase
        end
        if (cmd.capture) begin
            time_out        <= time_reg;
            out_pos_x       <= px_reg;
            out_pos_y       <= py_reg;
            out_vel_x       <= vx_reg;
            out_vel_y       <= vy_reg;
            total_energy    <= t3_reg;
            magnetic_moment <= t4_reg;
        end
    end

endmodule

// ===== rtl/cpfi_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpfi_ctrl
// Controller: item handshake, sample counter, microcode sequencer and the
// result beat valid flag.
// ----------------------------------------------------------------------------
module cpfi_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  logic [1:0]            scheme_select,
    input  logic [15:0]           sample_interval,
    output cpfi_pkg::dp_cmd_t     cmd,
    input  cpfi_pkg::dp_stat_t    stat
);
    import cpfi_pkg::*;

    ctrl_state_t     state_reg, state_next;
    logic [PCW-1:0]  pc_reg, pc_next;
    logic            in_emit_reg, in_emit_next;
    logic            emit_pend_reg, emit_pend_next;
    logic [15:0]     since_reg, since_next;
    logic            mv_reg, mv_next;
    logic            accept;
    uop_t            cur;
    opcode_t         opc;
    logic [PCW-1:0]  scheme_pc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            in_emit_reg   <= 1'b0;
            emit_pend_reg <= 1'b0;
            since_reg     <= '0;
            mv_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            in_emit_reg   <= in_emit_next;
            emit_pend_reg <= emit_pend_next;
            since_reg     <= since_next;
            mv_reg        <= mv_next;
        end
    end

    always_comb begin
        opc = opcode_t'(s_opcode);
        cur = UCODE[pc_reg];
        unique case (scheme_t'(scheme_select))
            SCH_EULER:  scheme_pc = PC_EULER;
            SCH_CROMER: scheme_pc = PC_CROMER;
            SCH_VERLET: scheme_pc = PC_VERLET;
            SCH_RK2:    scheme_pc = PC_RK2;
            default:    scheme_pc = PC_EULER;
        endcase
        s_ready = (state_reg == ST_IDLE);
        accept  = s_valid && s_ready;

        state_next     = state_reg;
        pc_next        = pc_reg;
        in_emit_next   = in_emit_reg;
        emit_pend_next = emit_pend_reg;
        since_next     = since_reg;
        mv_next        = (mv_reg && m_ready) ? 1'b0 : mv_reg;
        cmd            = '0;
        cmd.uop        = cur;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (opc)
                        OPC_LOAD: begin
                            cmd.load     = 1'b1;
                            since_next   = 16'd1;
                            pc_next      = PC_EMIT;
                            in_emit_next = 1'b1;
                            state_next   = ST_ISSUE;
                        end
                        OPC_STEP: begin
                            cmd.tadv       = 1'b1;
                            emit_pend_next = (since_reg >= sample_interval);
                            since_next     = (since_reg >= sample_interval)
                                           ? 16'd1 : since_reg + 16'd1;
                            pc_next        = scheme_pc;
                            in_emit_next   = 1'b0;
                            state_next     = ST_ISSUE;
                        end
                        OPC_FLUSH: begin
                            // a flush right after a sample only bumps the counter
                            if (since_reg != 16'd1) begin
                                since_next   = 16'd1;
                                pc_next      = PC_EMIT;
                                in_emit_next = 1'b1;
                                state_next   = ST_ISSUE;
                            end else begin
                                since_next = 16'd2;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE: begin
                if (cur.op == OP_END) begin
                    if (in_emit_reg) begin
                        state_next = ST_DELIVER;
                    end else if (emit_pend_reg) begin
                        emit_pend_next = 1'b0;
                        in_emit_next   = 1'b1;
                        pc_next        = PC_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.issue  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (stat.done) begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_DELIVER: begin
                if (!mv_reg || m_ready) begin
                    cmd.capture  = 1'b1;
                    mv_next      = 1'b1;
                    in_emit_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = mv_reg;

endmodule

// ===== tb/charged_particle_field_integrator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charged_particle_field_integrator_top_tb
// Self-checking bench for the particle pusher: a short directed table, then
// random load/step/flush runs over several register settings, all schemes.
// Results are compared beat by beat with an in-bench fixed-point predictor or with a row's given sample.
// ----------------------------------------------------------------------------
module charged_particle_field_integrator_top_tb;
    import cpfi_pkg::*;

    localparam int  N_PHASES    = 12;
    localparam int  PHASE_ITEMS = 90;
    localparam int  SETTLE      = 400;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam longint QMAX     = 64'sd2147483647;
    localparam longint QMIN     = -64'sd2147483648;
    localparam longint TMAX     = (64'sd1 <<< 47) - 1;
    localparam longint Q1       = 64'sd65536;
    localparam longint QH       = 64'sd32768;

    typedef struct packed {
        logic [TW-1:0] t;
        logic [31:0]   px, py, vx, vy, energy, moment;
    } sample_t;

    typedef struct {
        opcode_t     op;
        logic [31:0] px, py, vx, vy;
        bit          typed;
        sample_t     want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic signed [31:0] s_init_pos_x = '0, s_init_pos_y = '0;
    logic signed [31:0] s_init_vel_x = '0, s_init_vel_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [TW-1:0] m_time_out;
    logic signed [31:0] m_out_pos_x, m_out_pos_y, m_out_vel_x, m_out_vel_y;
    logic signed [31:0] m_total_energy, m_magnetic_moment;

    // predictor state and registers
    scheme_t sch;
    longint  dt_q, mass_q, chg_q, fb_q, fg_q, ef_q, interval;
    longint  px_q, py_q, vx_q, vy_q, t_acc, since;

    sample_t samples_due[$];
    int      n_err = 0;
    int      cycles = 0;
    bit      no_idle = 1'b0;
    int      ready_hold = 0;

    always #2 aclk = ~aclk;

    charged_particle_field_integrator_top u_top (.*);

    function automatic longint clip(longint v);
        return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return clip((a * b) >>> 16);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        if (b == 0) return a < 0 ? QMIN : QMAX;
        return clip((a * Q1) / b);
    endfunction

    function automatic longint field_at(longint x);
        return fx_mul(fb_q, clip(Q1 + fx_mul(fg_q, x)));
    endfunction

    function automatic longint accel_x(longint vy, longint x);
        return fx_mul(fx_mul(fx_div(chg_q, mass_q), field_at(x)), vy);
    endfunction

    function automatic longint accel_y(longint vx, longint x);
        return fx_mul(fx_div(chg_q, mass_q), clip(ef_q - fx_mul(field_at(x), vx)));
    endfunction

    function automatic void push_particle();
        longint hd, ax0, ay0, kvx, kvy, kx, ky, mvx, mvy, mx, my;
        hd = fx_mul(dt_q, QH);
        case (sch)
            SCH_EULER: begin
                ax0 = accel_x(vy_q, px_q);
                ay0 = accel_y(vx_q, px_q);
                px_q = clip(px_q + fx_mul(vx_q, dt_q));
                py_q = clip(py_q + fx_mul(vy_q, dt_q));
                vx_q = clip(vx_q + fx_mul(ax0, dt_q));
                vy_q = clip(vy_q + fx_mul(ay0, dt_q));
            end
            SCH_CROMER: begin
                vx_q = clip(vx_q + fx_mul(accel_x(vy_q, px_q), dt_q));
                vy_q = clip(vy_q + fx_mul(accel_y(vx_q, px_q), dt_q));
                px_q = clip(px_q + fx_mul(vx_q, dt_q));
                py_q = clip(py_q + fx_mul(vy_q, dt_q));
            end
            SCH_VERLET: begin
                px_q = clip(px_q + fx_mul(vx_q, hd));
                py_q = clip(py_q + fx_mul(vy_q, hd));
                vx_q = clip(vx_q + fx_mul(accel_x(vy_q, px_q), hd));
                vy_q = clip(vy_q + fx_mul(accel_y(vx_q, px_q), hd));
                vy_q = clip(vy_q + fx_mul(accel_y(vx_q, px_q), hd));
                vx_q = clip(vx_q + fx_mul(accel_x(vy_q, px_q), hd));
                py_q = clip(py_q + fx_mul(vy_q, hd));
                px_q = clip(px_q + fx_mul(vx_q, hd));
            end
            default: begin
                kvx = fx_mul(dt_q, accel_x(vy_q, px_q));
                kvy = fx_mul(dt_q, accel_y(vx_q, px_q));
                kx  = fx_mul(dt_q, vx_q);
                ky  = fx_mul(dt_q, vy_q);
                mvx = clip(vx_q + fx_mul(QH, kvx));
                mvy = clip(vy_q + fx_mul(QH, kvy));
                mx  = clip(px_q + fx_mul(QH, kx));
                my  = clip(py_q + fx_mul(QH, ky));
                kvx = fx_mul(dt_q, accel_x(mvy, mx));
                kvy = fx_mul(dt_q, accel_y(mvx, mx));
                kx  = fx_mul(dt_q, mvx);
                ky  = fx_mul(dt_q, mvy);
                vx_q = clip(vx_q + kvx);
                vy_q = clip(vy_q + kvy);
                px_q = clip(px_q + kx);
                py_q = clip(py_q + ky);
            end
        endcase
    endfunction

    function automatic sample_t diag_sample();
        sample_t s;
        longint ke, pe;
        ke = fx_mul(QH, fx_mul(mass_q, clip(fx_mul(vx_q, vx_q) + fx_mul(vy_q, vy_q))));
        pe = fx_mul(fx_mul(chg_q, ef_q), py_q);
        s.t      = t_acc[TW-1:0];
        s.px     = px_q[31:0];
        s.py     = py_q[31:0];
        s.vx     = vx_q[31:0];
        s.vy     = vy_q[31:0];
        s.energy = 32'(clip(ke - pe));
        s.moment = 32'(fx_div(ke, field_at(px_q)));
        return s;
    endfunction

    // updates the predicted state; returns 1 when the beat yields a sample
    function automatic bit predict_item(opcode_t op, logic [31:0] ipx, logic [31:0] ipy,
                                        logic [31:0] ivx, logic [31:0] ivy,
                                        output sample_t s);
        s = '0;
        case (op)
            OPC_LOAD: begin
                px_q = longint'(signed'(ipx));
                py_q = longint'(signed'(ipy));
                vx_q = longint'(signed'(ivx));
                vy_q = longint'(signed'(ivy));
                t_acc = 0;
                since = 1;
                s = diag_sample();
                return 1;
            end
            OPC_STEP: begin
                push_particle();
                t_acc = t_acc + dt_q;
                if (t_acc > TMAX) t_acc = TMAX;
                if (since >= interval) begin
                    since = 1;
                    s = diag_sample();
                    return 1;
                end
                since = (since + 1) & 64'hffff;
                return 0;
            end
            OPC_FLUSH: begin
                if (since != 1) begin
                    since = 1;
                    s = diag_sample();
                    return 1;
                end
                since = 2;
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SCHEME:   sch = scheme_t'(val[1:0]);
            REG_DT:       dt_q = longint'(val[30:0]);
            REG_MASS:     mass_q = longint'(val[30:0]);
            REG_CHARGE:   chg_q = longint'(signed'(val));
            REG_FBASE:    fb_q = longint'(signed'(val));
            REG_FGRAD:    fg_q = longint'(signed'(val));
            REG_EFIELD:   ef_q = longint'(signed'(val));
            default:      interval = longint'(val[15:0]);
        endcase
        @(posedge aclk);
    endtask

    // send one beat; valid is only dropped when a gap follows
    task automatic send_beat(opcode_t op, logic [31:0] ipx, logic [31:0] ipy,
                             logic [31:0] ivx, logic [31:0] ivy, bit typed, sample_t want);
        int gap;
        sample_t s;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_init_pos_x <= ipx;
        s_init_pos_y <= ipy;
        s_init_vel_x <= ivx;
        s_init_vel_y <= ivy;
        do @(posedge aclk); while (!s_ready);
        if (predict_item(op, ipx, ipy, ivx, ivy, s))
            samples_due.push_back(typed ? want : s);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (samples_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0;
                default: return 32'hffff_ffff;
            endcase
            default: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
        endcase
    endfunction

    function automatic logic [31:0] small_signed(int span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    // one register setting per phase, with extreme values in every phase after the first
    task automatic configure(int p);
        write_reg(REG_SCHEME, 32'(p % 4));
        write_reg(REG_DT, p == 1 ? 32'd1 : p == 2 ? 32'h7fff_ffff
                                         : 32'($urandom_range(1, 4096)));
        write_reg(REG_MASS, p == 3 ? 32'd1 : p == 4 ? 32'h7fff_ffff
                          : p == 5 ? 32'd0 : 32'($urandom_range(1 << 14, 1 << 18)));
        write_reg(REG_CHARGE, p == 6 ? 32'h8000_0000 : p == 7 ? 32'h7fff_ffff
                                     : small_signed(1 << 18));
        write_reg(REG_FBASE, p == 8 ? 32'd0 : p == 9 ? 32'h8000_0000
                                    : small_signed(1 << 18));
        write_reg(REG_FGRAD, p == 10 ? 32'h7fff_ffff : p == 11 ? 32'h8000_0000
                                     : small_signed(1 << 12));
        write_reg(REG_EFIELD, p == 6 ? 32'h8000_0000 : p == 9 ? 32'h7fff_ffff
                                     : small_signed(1 << 17));
        write_reg(REG_INTERVAL, p == 10 ? 32'd65535 : p == 1 ? 32'd1
                                        : 32'($urandom_range(1, 6)));
        cfg_we <= 1'b0;
    endtask

    stim_row_t dir_rows[] = '{
        '{OPC_FLUSH, 0, 0, 0, 0, 1'b1, '0},
        '{OPC_FLUSH, 0, 0, 0, 0, 1'b0, '0},
        '{OPC_STEP,  0, 0, 0, 0, 1'b0, '0},
        '{OPC_NONE,  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
        '{OPC_LOAD,  32'h7fff_ffff, 0, 0, 0, 1'b1,
          '{0, 32'h7fff_ffff, 0, 0, 0, 0, 0}},
        '{OPC_LOAD,  0, 0, 32'h0001_0000, 0, 1'b1,
          '{0, 0, 0, 32'h0001_0000, 0, 32'h0000_8000, 32'h0000_8000}},
        '{OPC_STEP,  0, 0, 0, 0, 1'b0, '0},
        '{OPC_STEP,  0, 0, 0, 0, 1'b0, '0},
        '{OPC_LOAD,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
        '{OPC_STEP,  0, 0, 0, 0, 1'b0, '0},
        '{OPC_FLUSH, 0, 0, 0, 0, 1'b0, '0},
        '{OPC_LOAD,  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0, '0},
        '{OPC_STEP,  0, 0, 0, 0, 1'b0, '0},
        '{OPC_LOAD,  32'h0002_0000, 32'hfffe_0000, 32'hffff_0000, 32'h0003_8000, 1'b0, '0},
        '{OPC_STEP,  0, 0, 0, 0, 1'b0, '0},
        '{OPC_STEP,  0, 0, 0, 0, 1'b0, '0},
        '{OPC_NONE,  0, 0, 0, 0, 1'b0, '0},
        '{OPC_FLUSH, 0, 0, 0, 0, 1'b0, '0},
        '{OPC_FLUSH, 0, 0, 0, 0, 1'b0, '0},
        '{OPC_STEP,  0, 0, 0, 0, 1'b0, '0}
    };

    initial begin
        sample_t none;
        opcode_t op;
        int      pick;
        none = '0;
        sch = SCH_EULER; dt_q = 65; mass_q = Q1; chg_q = Q1; fb_q = Q1;
        fg_q = 0; ef_q = 0; interval = 1;
        px_q = 0; py_q = 0; vx_q = 0; vy_q = 0; t_acc = 0; since = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].op, dir_rows[i].px, dir_rows[i].py, dir_rows[i].vx,
                      dir_rows[i].vy, dir_rows[i].typed, dir_rows[i].want);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            no_idle = (p % 5 == 4);
            configure(p);
            // mostly a load with random content followed by steps and flushes
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                op = (n == 0 || pick < 10) ? OPC_LOAD : pick < 80 ? OPC_STEP
                   : pick < 95 ? OPC_FLUSH : OPC_NONE;
                send_beat(op, rand_word(), rand_word(), rand_word(), rand_word(), 1'b0, none);
            end
            drain();
        end

        if (n_err == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // result side back-pressure: a fresh stall count after every beat
    always @(posedge aclk) begin
        int nxt;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold <= 0;
        end else if (m_valid && m_ready) begin
            nxt = no_idle ? 0 : $urandom_range(0, 8);
            ready_hold <= nxt;
            m_ready <= (nxt == 0);
        end else if (ready_hold > 1) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_hold <= 0;
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        sample_t     want;
        logic [47:0] got_f[7], want_f[7];
        string       names[7];
        bit          bad;
        names = '{"time_out", "pos_x", "pos_y", "vel_x", "vel_y", "energy", "moment"};
        if (aresetn && m_valid && m_ready) begin
            if (samples_due.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected sample beat at cycle %0d", cycles);
            end else begin
                want = samples_due.pop_front();
                // fields compare as raw bit patterns, zero-extended
                got_f  = '{48'(m_time_out), 48'($unsigned(m_out_pos_x)),
                           48'($unsigned(m_out_pos_y)), 48'($unsigned(m_out_vel_x)),
                           48'($unsigned(m_out_vel_y)), 48'($unsigned(m_total_energy)),
                           48'($unsigned(m_magnetic_moment))};
                want_f = '{48'(want.t), 48'(want.px), 48'(want.py), 48'(want.vx),
                           48'(want.vy), 48'(want.energy), 48'(want.moment)};
                bad = 1'b0;
                for (int k = 0; k < 7; k++) begin
                    if (got_f[k] !== want_f[k]) begin
                        if (!bad) n_err++;
                        if (n_err <= 10)
                            $display("mismatch %s: exp %h got %h (cycle %0d)",
                                     names[k], want_f[k], got_f[k], cycles);
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/cpfi_pkg.sv
rtl/cpfi_div.sv
rtl/cpfi_dp.sv
rtl/cpfi_ctrl.sv
rtl/charged_particle_field_integrator_top.sv
tb/charged_particle_field_integrator_top_tb.sv
